/* hdl/line_rasterizer_unit_macros.svh */
// shared assertion macros for the line rasterizer
`ifndef LINE_RASTERIZER_UNIT_MACROS_SVH
`define LINE_RASTERIZER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LRU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lru_pkg.sv */
package lru_pkg;

    localparam int FIELD_COORD_W = 6;
    localparam int COLOR_W       = 8;
    localparam int SIZE_W        = 7;
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_TDATA_W   = 40;

    localparam int START_X_LSB = 0;
    localparam int START_Y_LSB = 6;
    localparam int END_X_LSB   = 12;
    localparam int END_Y_LSB   = 18;
    localparam int RED_LSB     = 24;
    localparam int GREEN_LSB   = 32;
    localparam int BLUE_LSB    = 40;

    localparam logic REG_SURFACE_WIDTH  = 1'b0;
    localparam logic REG_SURFACE_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [2:0]
    {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    typedef struct packed
    {
        logic load;
        logic setup;
        logic step;
    } cmd_t;

    typedef struct packed
    {
        logic out_free;
        logic last;
    } status_t;

endpackage

/* hdl/lru_ctrl.sv */
`include "line_rasterizer_unit_macros.svh"

module lru_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lru_pkg::status_t status,
    output lru_pkg::cmd_t    cmd
);

    lru_pkg::state_t state_reg;
    lru_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            lru_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lru_pkg::ST_SETUP;
                end
            end
            lru_pkg::ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = lru_pkg::ST_RUN;
            end
            lru_pkg::ST_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.step = 1'b1;
                    if (status.last)
                    begin
                        state_next = lru_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lru_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lru_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `LRU_ASSERT_NEXT(a_last_step_ends_line,
        cmd.step && status.last, state_reg == lru_pkg::ST_IDLE,
        "line did not end after its last pixel")
    `LRU_ASSERT_NEXT(a_load_then_setup,
        cmd.load, cmd.setup && !s_tready,
        "setup did not follow a new request")
    `LRU_ASSERT_SAME(a_step_needs_room,
        cmd.step, status.out_free && state_reg == lru_pkg::ST_RUN,
        "pixel issued without output room")

endmodule

/* hdl/lru_datapath.sv */
`include "line_rasterizer_unit_macros.svh"

module lru_datapath
#(
    parameter int COORD_BITS = 6
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [lru_pkg::SIZE_W-1:0]          cfg_data,
    input  logic [lru_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lru_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    input  lru_pkg::cmd_t                       cmd,
    output lru_pkg::status_t                    status
);

    localparam int TERM_BITS = COORD_BITS + 3;
    localparam int FW        = lru_pkg::FIELD_COORD_W;
    localparam int SW        = lru_pkg::SIZE_W;
    localparam int CW        = lru_pkg::COLOR_W;
    localparam int PIX_W     = 2 * FW + 3 * CW;

    logic [SW-1:0] width_reg, width_next;
    logic [SW-1:0] height_reg, height_next;

    logic [COORD_BITS-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [3*CW-1:0]       color_reg;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] end_reg, end_next;
    logic [TERM_BITS-1:0]  term_reg, term_next;
    logic [TERM_BITS-1:0]  inc_lo_reg, inc_lo_next;
    logic [TERM_BITS-1:0]  inc_hi_reg, inc_hi_next;
    logic                  up_reg, up_next;
    logic                  steep_reg, steep_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic [3*CW-1:0]       out_color_reg;
    logic                  out_inside_reg, out_last_reg;

    logic [COORD_BITS:0]   dx, dy;
    logic [COORD_BITS-1:0] adx, ady;
    logic                  dx_neg, dy_neg, dx_pos, dy_pos;
    logic [TERM_BITS-1:0]  two_adx, two_ady;
    logic                  take_minor;
    logic [COORD_BITS-1:0] cur_major;
    logic [COORD_BITS-1:0] minor_stepped_x, minor_stepped_y;
    logic                  pix_inside;
    logic                  is_last;

    // configuration
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lru_pkg::REG_SURFACE_WIDTH:  width_next  = cfg_data;
                lru_pkg::REG_SURFACE_HEIGHT: height_next = cfg_data;
                default:                     width_next  = width_reg;
            endcase
        end
    end

    // setup arithmetic
    always_comb
    begin
        dx      = {1'b0, x2_reg} - {1'b0, x1_reg};
        dy      = {1'b0, y2_reg} - {1'b0, y1_reg};
        dx_neg  = dx[COORD_BITS];
        dy_neg  = dy[COORD_BITS];
        dx_pos  = !dx_neg && (dx != '0);
        dy_pos  = !dy_neg && (dy != '0);
        adx     = dx_neg ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady     = dy_neg ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        two_adx = TERM_BITS'(adx) << 1;
        two_ady = TERM_BITS'(ady) << 1;
    end

    // walk step
    always_comb
    begin
        take_minor = steep_reg ? !(term_reg[TERM_BITS-1] || (term_reg == '0))
                               : !term_reg[TERM_BITS-1];
        cur_major  = steep_reg ? cur_y_reg : cur_x_reg;
        is_last    = (cur_major == end_reg);
        minor_stepped_x = up_reg ? cur_x_reg + 1'b1 : cur_x_reg - 1'b1;
        minor_stepped_y = up_reg ? cur_y_reg + 1'b1 : cur_y_reg - 1'b1;
        pix_inside = (SW'(cur_x_reg) < width_reg) && (SW'(cur_y_reg) < height_reg);
    end

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        end_next    = end_reg;
        term_next   = term_reg;
        inc_lo_next = inc_lo_reg;
        inc_hi_next = inc_hi_reg;
        up_next     = up_reg;
        steep_next  = steep_reg;
        if (cmd.setup)
        begin
            up_next    = (dx_neg && dy_neg) || (dx_pos && dy_pos);
            steep_next = ady > adx;
            if (ady > adx)
            begin
                term_next   = two_adx - TERM_BITS'(ady);
                inc_lo_next = two_adx;
                inc_hi_next = two_adx - two_ady;
                cur_x_next  = dy_neg ? x2_reg : x1_reg;
                cur_y_next  = dy_neg ? y2_reg : y1_reg;
                end_next    = dy_neg ? y1_reg : y2_reg;
            end
            else
            begin
                term_next   = two_ady - TERM_BITS'(adx);
                inc_lo_next = two_ady;
                inc_hi_next = two_ady - two_adx;
                cur_x_next  = dx_neg ? x2_reg : x1_reg;
                cur_y_next  = dx_neg ? y2_reg : y1_reg;
                end_next    = dx_neg ? x1_reg : x2_reg;
            end
        end
        else if (cmd.step)
        begin
            term_next = term_reg + (take_minor ? inc_hi_reg : inc_lo_reg);
            if (steep_reg)
            begin
                cur_y_next = cur_y_reg + 1'b1;
                if (take_minor)
                begin
                    cur_x_next = minor_stepped_x;
                end
            end
            else
            begin
                cur_x_next = cur_x_reg + 1'b1;
                if (take_minor)
                begin
                    cur_y_next = minor_stepped_y;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= lru_pkg::SIZE_RESET;
            height_reg    <= lru_pkg::SIZE_RESET;
            out_valid_reg <= 1'b0;
            steep_reg     <= 1'b0;
            up_reg        <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            end_reg       <= '0;
            term_reg      <= '0;
            inc_lo_reg    <= '0;
            inc_hi_reg    <= '0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            out_valid_reg <= out_valid_next;
            steep_reg     <= steep_next;
            up_reg        <= up_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            end_reg       <= end_next;
            term_reg      <= term_next;
            inc_lo_reg    <= inc_lo_next;
            inc_hi_reg    <= inc_hi_next;
        end
    end

    // request and pixel payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x1_reg    <= s_tdata[lru_pkg::START_X_LSB +: COORD_BITS];
            y1_reg    <= s_tdata[lru_pkg::START_Y_LSB +: COORD_BITS];
            x2_reg    <= s_tdata[lru_pkg::END_X_LSB +: COORD_BITS];
            y2_reg    <= s_tdata[lru_pkg::END_Y_LSB +: COORD_BITS];
            color_reg <= s_tdata[lru_pkg::RED_LSB +: 3 * CW];
        end
        if (cmd.step)
        begin
            out_x_reg      <= cur_x_reg;
            out_y_reg      <= cur_y_reg;
            out_color_reg  <= color_reg;
            out_inside_reg <= pix_inside;
            out_last_reg   <= is_last;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign status.last     = is_last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = lru_pkg::OUT_TDATA_W'(
        PIX_W'({out_color_reg, FW'(out_y_reg), FW'(out_x_reg)}));
    assign m_tuser  = out_inside_reg;
    assign m_tlast  = out_last_reg;

    `LRU_ASSERT_SAME(a_major_within_end,
        cmd.step, cur_major <= end_reg,
        "major coordinate ran past the line end")
    `LRU_ASSERT_NEXT(a_step_fills_output,
        cmd.step, m_tvalid && (m_tlast == $past(is_last)),
        "issued pixel did not reach the output")
    `LRU_ASSERT_SAME(a_no_overwrite,
        cmd.step, !out_valid_reg || m_tready,
        "waiting pixel overwritten")

endmodule

/* hdl/line_rasterizer_unit.sv */
// the first pixel is valid once the request is loaded, set up and its first step registered
// a line has n pixels (n = major-axis length + 1, at most 64)
// the step loop of the controller emits one pixel a cycle and stalls while the output waits
// a new request is taken once the last pixel of a line is in the output register
// reset: asynchronous, active low; idle, no pixel valid, surface size 64 by 64
module line_rasterizer_unit
#(
    parameter int COORD_BITS = 6
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [lru_pkg::SIZE_W-1:0]          cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // start_x, start_y, end_x, end_y, red_in, green_in, blue_in
    input  logic [lru_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_x, pixel_y, red_out, green_out, blue_out, zero fill
    output logic [lru_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // inside_res
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast
);

    lru_pkg::cmd_t    cmd;
    lru_pkg::status_t status;

    lru_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lru_datapath
    #(
        .COORD_BITS (COORD_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
